// File: hw/rtl/dib_pkg.sv
// shared types and constants for the deferred invalidation batcher
// no dependencies; used by every module under hw/rtl except dib_ram

package dib_pkg;

    // number of batched page entries
    localparam int SLOTS = 32;
    // slot index and fill count widths
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int ADDR_W  = 64;
    localparam int ENTRY_W = 2 * ADDR_W;

    // request opcodes (code 3 means nothing and is ignored)
    typedef logic [1:0] t_op;
    localparam t_op OP_PAGE  = 2'd0;
    localparam t_op OP_ALL   = 2'd1;
    localparam t_op OP_DRAIN = 2'd2;

    // kind of an emitted invalidation
    localparam logic KIND_PAGE = 1'b0;
    localparam logic KIND_ALL  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic apply;       // apply a page or flush-all request
        logic rd_first;    // read slot 0
        logic rd_next;     // read the slot after the one held
        logic load_entry;  // move the read slot into the output word
        logic load_flush;  // put a flush-all word in the output register
        logic clear_batch; // empty the batcher
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pending;   // full flush owed
        logic empty;     // no stored entries
        logic out_free;  // output register can take a word this cycle
        logic at_last;   // held slot is the final stored entry
    } t_status;

endpackage

// File: hw/rtl/deferred_invalidation_batcher.sv
// top level of the deferred invalidation batcher
// depends on dib_pkg, dib_ctrl, dib_datapath (and dib_ram below it)
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata page/root
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser kind, tdata addr/root, tlast
//
// page, flush-all and ignored requests are accepted back to back
// a drain with a flush pending emits one word; otherwise one word per stored
//   entry, one per cycle while m_axis_tready allows, from the slot ram's registered
//   read port, which first registers slot 0; no request is taken while it runs
// a drain with nothing pending is accepted while idle and emits nothing
// m_axis_tready low holds the output register and pauses the drain
// reset is synchronous, active low; it empties the batcher, slot contents stay

module deferred_invalidation_batcher (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] page_address, [127:64] root_table
    input  logic [1:0]   s_axis_tuser,  // [1:0] opcode

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // [63:0] out_address, [127:64] out_root
    output logic [0:0]   m_axis_tuser,  // [0] flush_kind
    output logic         m_axis_tlast   // last word of a drain
);

    dib_pkg::t_cmd    cmd;
    dib_pkg::t_status status;

    dib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_op    (s_axis_tuser),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dib_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_op    (s_axis_tuser),
        .i_req_addr  (s_axis_tdata[63:0]),
        .i_req_root  (s_axis_tdata[127:64]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser[0]),
        .o_out_addr  (m_axis_tdata[63:0]),
        .o_out_root  (m_axis_tdata[127:64]),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// File: hw/rtl/dib_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module dib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/dib_datapath.sv
// datapath: slot memory, fill count, pending flag, read index, output register
// depends on dib_pkg and dib_ram

module dib_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dib_pkg::t_cmd                i_cmd,
    output dib_pkg::t_status             o_status,
    input  dib_pkg::t_op                 i_req_op,
    input  logic [dib_pkg::ADDR_W-1:0]   i_req_addr,
    input  logic [dib_pkg::ADDR_W-1:0]   i_req_root,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_out_kind,
    output logic [dib_pkg::ADDR_W-1:0]   o_out_addr,
    output logic [dib_pkg::ADDR_W-1:0]   o_out_root,
    output logic                         o_out_last
);

    logic [dib_pkg::CNT_W-1:0]   r_fill;
    logic                        r_pending;
    logic [dib_pkg::IDX_W-1:0]   r_rd_idx;
    logic                        r_out_valid;
    logic                        r_out_kind;
    logic [dib_pkg::ADDR_W-1:0]  r_out_addr;
    logic [dib_pkg::ADDR_W-1:0]  r_out_root;
    logic                        r_out_last;

    logic                        full;
    logic                        wr_en;
    logic                        rd_en;
    logic [dib_pkg::IDX_W-1:0]   rd_addr;
    logic [dib_pkg::ENTRY_W-1:0] rd_data;

    assign full  = (r_fill == dib_pkg::CNT_W'(dib_pkg::SLOTS));
    assign wr_en = i_cmd.apply && (i_req_op == dib_pkg::OP_PAGE) && !r_pending && !full;

    assign rd_en   = i_cmd.rd_first || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_first ? '0 : r_rd_idx + 1'b1;

    dib_ram #(
        .WIDTH (dib_pkg::ENTRY_W),
        .DEPTH (dib_pkg::SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[dib_pkg::IDX_W-1:0]),
        .i_wr_data ({i_req_root, i_req_addr}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_pending <= 1'b0;
        end else if (i_cmd.clear_batch) begin
            r_fill    <= '0;
            r_pending <= 1'b0;
        end else if (i_cmd.apply) begin
            case (i_req_op)
                dib_pkg::OP_PAGE: begin
                    if (!r_pending) begin
                        if (full) begin
                            // list overflows into a full flush
                            r_pending <= 1'b1;
                            r_fill    <= '0;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                dib_pkg::OP_ALL: begin
                    r_pending <= 1'b1;
                    r_fill    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // read index follows the slot whose data sits in the ram output
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= rd_addr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_entry || i_cmd.load_flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_flush) begin
            r_out_kind <= dib_pkg::KIND_ALL;
            r_out_addr <= '0;
            r_out_root <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_entry) begin
            r_out_kind <= dib_pkg::KIND_PAGE;
            r_out_addr <= rd_data[dib_pkg::ADDR_W-1:0];
            r_out_root <= rd_data[dib_pkg::ENTRY_W-1:dib_pkg::ADDR_W];
            r_out_last <= o_status.at_last;
        end
    end

    assign o_status.pending  = r_pending;
    assign o_status.empty    = (r_fill == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.at_last  = (dib_pkg::CNT_W'(r_rd_idx) + 1'b1 == r_fill);

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_addr  = r_out_addr;
    assign o_out_root  = r_out_root;
    assign o_out_last  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dib_pkg::CNT_W'(dib_pkg::SLOTS))
        else $error("fill count beyond slot count");

    a_pending_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_fill == '0))
        else $error("entries stored while a full flush is pending");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_entry || i_cmd.load_flush) |-> o_status.out_free)
        else $error("output word overwritten before it was taken");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_batch |=> (r_fill == '0) && !r_pending)
        else $error("batcher not empty after a drain");

endmodule

// File: hw/rtl/dib_ctrl.sv
// controller: accepts requests and sequences a drain through the datapath
// depends on dib_pkg

module dib_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dib_pkg::t_op       i_in_op,
    input  dib_pkg::t_status   i_status,
    output dib_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == dib_pkg::OP_DRAIN) begin
                        if (i_status.pending) begin
                            n_state = ST_FLUSH;
                        end else if (!i_status.empty) begin
                            o_cmd.rd_first = 1'b1;
                            n_state        = ST_EMIT;
                        end
                    end else begin
                        o_cmd.apply = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.load_flush  = 1'b1;
                    o_cmd.clear_batch = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_entry = 1'b1;
                    if (i_status.at_last) begin
                        o_cmd.clear_batch = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !i_status.empty)
        else $error("draining entries from an empty list");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_entry && o_cmd.load_flush))
        else $error("two output loads in one cycle");

endmodule
